@@ src/bmhq_pkg.sv @@
// Package with shared constants and command codes for the binary min-heap queue.
`timescale 1ns / 1ps

package bmhq_pkg;

    // Default heap capacity in entries
    localparam int CAPACITY_DEF = 1024;

    // Field widths
    localparam int CMD_W   = 2;
    localparam int KEY_W   = 32;
    localparam int TOTAL_W = 11;

    // Stream widths, fields packed from bit 0 and padded to whole bytes
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 48;

    // Command codes; the unused code behaves as a peek
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd2;

    // Key reported while the heap is empty
    localparam logic [KEY_W-1:0] EMPTY_KEY = '1;

endpackage

@@ src/bmhq_ram.sv @@
// Heap key storage: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module bmhq_ram #(
    parameter int AW = 11
) (
    input  logic                          aclk,
    input  logic                          we,
    input  logic [AW-1:0]                 waddr,
    input  logic [bmhq_pkg::KEY_W-1:0]    wdata,
    input  logic                          re,
    input  logic [AW-1:0]                 raddr,
    output logic [bmhq_pkg::KEY_W-1:0]    rdata
);
    import bmhq_pkg::*;

    localparam int DEPTH = 2 ** AW;

    logic [KEY_W-1:0] mem [0:DEPTH-1];
    logic [KEY_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data valid the cycle after the address
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/binary_min_heap_queue_core.sv @@
// Top level of the binary min-heap priority queue with its sift sequencer.
//
//  channel | dir | tdata fields (lowest bit first)                      | ready rule
//  s_      | in  | cmd[1:0], value[33:2], zero pad [39:34]              | idle only
//  m_      | out | top_value[31:0], is_empty[32], entry_total[43:33],   | output reg
//          |     | overflow[44], zero pad [47:45]                       |
//
// An insert climbs from the new leaf towards the root, with one parent read and
// compare per level; a remove moves the last entry to the root and sinks it,
// reading both children and comparing per level. The single RAM read port and
// its registered data set the per-level cost; one comparator is shared.
// Reset clears the count and the control state; heap contents are not cleared.
// A new transfer is taken while a result still waits on m_; a stalled result
// holds the sequencer in its final state.
`timescale 1ns / 1ps

module binary_min_heap_queue_core #(
    parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // cmd[1:0], value[33:2], zeros above
    input  logic [bmhq_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // top_value[31:0], is_empty[32], entry_total[43:33], overflow[44], zeros above
    output logic [bmhq_pkg::M_DATA_W-1:0] m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready
);
    import bmhq_pkg::*;

    // Address width covers positions 1..CAPACITY and the count itself
    localparam int AW = $clog2(CAPACITY + 1);
    localparam logic [AW-1:0] CAP_L = AW'(CAPACITY);
    localparam logic [AW-1:0] ROOT  = AW'(1);

    typedef enum logic [3:0] {
        S_IDLE, S_UP, S_UPCMP, S_LAST, S_DN, S_DNL, S_DNR, S_DNC, S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     count_reg, count_next;
    logic [AW-1:0]     pos_reg,   pos_next;
    logic [AW-1:0]     idx_reg,   idx_next;
    logic [KEY_W-1:0]  key_reg,   key_next;    // key being inserted
    logic [KEY_W-1:0]  cur_reg,   cur_next;    // entry sinking from the root
    logic [KEY_W-1:0]  child_reg, child_next;  // left child
    logic [KEY_W-1:0]  best_reg,  best_next;   // smaller child
    logic [KEY_W-1:0]  top_reg,   top_next;    // copy of the root entry
    logic              ovf_reg,   ovf_next;
    logic              mvalid_reg, mvalid_next;
    logic [M_DATA_W-1:0] mdata_reg, mdata_next;

    // RAM port
    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [KEY_W-1:0]  mem_wdata, mem_rdata;

    // Shared comparator
    logic [KEY_W-1:0]  cmp_a, cmp_b;
    logic              key_lt;

    logic [AW:0]       left_w;
    logic [AW:0]       count_x;
    logic              has_right;
    logic [CMD_W-1:0]  in_cmd;
    logic [KEY_W-1:0]  in_value;

    assign in_cmd    = s_tdata[CMD_W-1:0];
    assign in_value  = s_tdata[CMD_W +: KEY_W];
    assign left_w    = {pos_reg, 1'b0};
    assign count_x   = {1'b0, count_reg};
    assign has_right = left_w < count_x;

    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = mvalid_reg;
    assign m_tdata   = mdata_reg;

    bmhq_ram #(.AW(AW)) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Comparator operand select per state
    always_comb begin
        case (state_reg)
            S_UPCMP: begin
                cmp_a = key_reg;
                cmp_b = mem_rdata;
            end
            S_DNR: begin
                cmp_a = mem_rdata;
                cmp_b = child_reg;
            end
            default: begin
                cmp_a = best_reg;
                cmp_b = cur_reg;
            end
        endcase
        key_lt = $signed(cmp_a) < $signed(cmp_b);
    end

    // Sequencer next state
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        idx_next    = idx_reg;
        key_next    = key_reg;
        cur_next    = cur_reg;
        child_next  = child_reg;
        best_next   = best_reg;
        ovf_next    = ovf_reg;
        mdata_next  = mdata_reg;
        mvalid_next = mvalid_reg & ~m_tready;
        mem_we      = 1'b0;
        mem_waddr   = pos_reg;
        mem_wdata   = key_reg;
        mem_re      = 1'b0;
        mem_raddr   = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    ovf_next   = 1'b0;
                    state_next = S_DONE;
                    case (in_cmd)
                        CMD_INSERT: begin
                            if (count_reg == CAP_L) begin
                                ovf_next = 1'b1;
                            end else begin
                                count_next = count_reg + AW'(1);
                                pos_next   = count_reg + AW'(1);
                                key_next   = in_value;
                                state_next = S_UP;
                            end
                        end
                        CMD_REMOVE: begin
                            if (count_reg != '0) begin
                                mem_re     = 1'b1;
                                mem_raddr  = count_reg;
                                state_next = S_LAST;
                            end
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            // Sift up: hole at pos, fetch parent
            S_UP: begin
                if (pos_reg == ROOT) begin
                    mem_we     = 1'b1;
                    state_next = S_DONE;
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = pos_reg >> 1;
                    state_next = S_UPCMP;
                end
            end
            S_UPCMP: begin
                mem_we = 1'b1;
                if (key_lt) begin
                    mem_wdata  = mem_rdata;
                    pos_next   = pos_reg >> 1;
                    state_next = S_UP;
                end else begin
                    state_next = S_DONE;
                end
            end
            // Last entry moves to the root hole
            S_LAST: begin
                cur_next   = mem_rdata;
                count_next = count_reg - AW'(1);
                pos_next   = ROOT;
                state_next = (count_reg == ROOT) ? S_DONE : S_DN;
            end
            // Sift down: fetch left child unless pos is a leaf
            S_DN: begin
                if (left_w > count_x) begin
                    mem_we     = 1'b1;
                    mem_wdata  = cur_reg;
                    state_next = S_DONE;
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = left_w[AW-1:0];
                    state_next = S_DNL;
                end
            end
            S_DNL: begin
                child_next = mem_rdata;
                mem_re     = 1'b1;
                mem_raddr  = left_w[AW-1:0] + AW'(1);
                state_next = S_DNR;
            end
            // Right wins only when present and strictly smaller
            S_DNR: begin
                if (has_right && key_lt) begin
                    best_next = mem_rdata;
                    idx_next  = left_w[AW-1:0] | AW'(1);
                end else begin
                    best_next = child_reg;
                    idx_next  = left_w[AW-1:0];
                end
                state_next = S_DNC;
            end
            S_DNC: begin
                mem_we = 1'b1;
                if (key_lt) begin
                    mem_wdata  = best_reg;
                    pos_next   = idx_reg;
                    state_next = S_DN;
                end else begin
                    mem_wdata  = cur_reg;
                    state_next = S_DONE;
                end
            end
            // Load the result once the output register is free
            S_DONE: begin
                if (!mvalid_reg || m_tready) begin
                    mvalid_next = 1'b1;
                    mdata_next  = '0;
                    mdata_next[KEY_W-1:0] = (count_reg == '0) ? EMPTY_KEY : top_reg;
                    mdata_next[KEY_W]     = (count_reg == '0);
                    mdata_next[KEY_W+1 +: TOTAL_W] = TOTAL_W'(count_reg);
                    mdata_next[KEY_W+1+TOTAL_W]    = ovf_reg;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Root copy follows every write to position 1
        top_next = (mem_we && mem_waddr == ROOT) ? mem_wdata : top_reg;
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            pos_reg    <= '0;
            idx_reg    <= '0;
            ovf_reg    <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            pos_reg    <= pos_next;
            idx_reg    <= idx_next;
            ovf_reg    <= ovf_next;
            mvalid_reg <= mvalid_next;
        end
        key_reg   <= key_next;
        cur_reg   <= cur_next;
        child_reg <= child_next;
        best_reg  <= best_next;
        top_reg   <= top_next;
        mdata_reg <= mdata_next;
    end

endmodule

@@ src/bmhq_checker.sv @@
// Port-level checker for the heap queue core and its bind to the top level.
`timescale 1ns / 1ps

module bmhq_checker #(
    parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [bmhq_pkg::M_DATA_W-1:0] m_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready
);
    import bmhq_pkg::*;

    localparam logic [TOTAL_W-1:0] CAP_T = TOTAL_W'(CAPACITY);

    logic [KEY_W-1:0]   top_f;
    logic               empty_f;
    logic [TOTAL_W-1:0] total_f;
    logic               ovf_f;

    assign top_f   = m_tdata[KEY_W-1:0];
    assign empty_f = m_tdata[KEY_W];
    assign total_f = m_tdata[KEY_W+1 +: TOTAL_W];
    assign ovf_f   = m_tdata[KEY_W+1+TOTAL_W];

    // No result right after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Empty flag agrees with the count, and an empty heap reports the fixed key
    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((empty_f == (total_f == '0)) && (!empty_f || top_f == EMPTY_KEY)))
        else $error("empty flag disagrees with entry count or key");

    // Input not ready in the cycle after an accepted transfer
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready right after a transfer");

    // A dropped insert only happens at full capacity
    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && ovf_f) |-> (total_f == CAP_T))
        else $error("overflow reported below capacity");

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind binary_min_heap_queue_core bmhq_checker #(.CAPACITY(CAPACITY)) u_bmhq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
